>>> rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Clocked check, masked while reset is high.
`define IDR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also runs through reset.
`define IDR_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IDR_ASSERT(lbl, clk, rst, prop, msg)
`define IDR_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/idr_pkg.sv
package idr_pkg;

   // default header depth in 8-byte words
   localparam int HEADER_WORDS_DEF = 10;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_IPIP     = 8'd4;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;

   localparam int STRIP_BYTES   = 34;
   localparam int MIN_ETH_LEN   = 14;
   localparam int MIN_IP_LEN    = 34;
   localparam int MIN_INNER_LEN = 68;
   localparam int MIN_PORT_LEN  = 76;

   // inner IPv4 header checksum: five lanes of two 16-bit words
   localparam int CSUM_LANES = 5;
   localparam int CSUM_BASE  = STRIP_BYTES + 14;

   localparam logic [31:0] TARGET_RESET = 32'h0A00_0006;

   typedef enum logic [2:0] {
      V_TX        = 3'd0,
      V_PASS      = 3'd1,
      V_REWRITTEN = 3'd2,
      V_DROP      = 3'd3,
      V_ABORT     = 3'd4
   } verdict_type;

   typedef struct packed {
      verdict_type  verdict;
      logic         out_end;
      logic [3:0]   out_count;
      logic [63:0]  out_word;
   } rsp_item_type;

endpackage

>>> rtl/idr_csum_lane.sv
module idr_csum_lane
   import idr_pkg::*;
(
   input  logic [15:0] hi_word,
   input  logic [15:0] lo_word,
   output logic [16:0] part_sum
);

   // one lane of the ones-complement header sum, carry kept for the merge
   assign part_sum = {1'b0, hi_word} + {1'b0, lo_word};

endmodule

>>> rtl/idr_out_fifo.sv
module idr_out_fifo
   import idr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_item_type push_item,
   output logic         space,
   input  logic         pop_ready,
   output logic         pop_valid,
   output rsp_item_type pop_item
);

   rsp_item_type mem_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         pop;

   assign space     = (cnt_ff != 2'd2);
   assign pop_valid = (cnt_ff != 2'd0);
   assign pop_item  = mem_ff[rd_ptr_ff];
   assign pop       = pop_valid && pop_ready;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> rtl/ipip_decap_reflect_rewriter_unit.sv
// IPIP decapsulating reflector. Frames arrive as 8-byte words, first byte in the
// top bits. The first HEADER_WORDS words are captured at one word per cycle
// (capture ends early on the frame's last word); a verdict and the header
// checksum are then formed in states DECIDE and MERGE (five checksum lanes,
// then a merge). With input held off, the rewritten header drains at one result
// per cycle while the queue has space, up to HEADER_WORDS results. After that the
// body streams at one word per cycle while the queue has space, except that a
// last word which spills into a second result holds input off until the second
// result is queued. Dropped and aborted frames give one result with out_count 0
// and out_end set; their remaining words are taken and discarded. Results pass
// through a two-entry output queue, so input keeps moving while a result waits.
`include "assert_macros.svh"

module ipip_decap_reflect_rewriter_unit
   import idr_pkg::*;
#(
   parameter int HEADER_WORDS = HEADER_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: word [63:0], byte_count [67:64], zero pad [71:68]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,
   input  logic        req_tlast,
   // rsp_tdata: out_word [63:0], out_count [67:64], zero pad [71:68]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,
   output logic        rsp_tlast,
   // rsp_tuser: verdict [2:0]
   output logic [2:0]  rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   localparam int HB  = HEADER_WORDS * 8;
   localparam int WSW = $clog2(HEADER_WORDS);
   localparam int LW  = $clog2(HB + 1);
   localparam int RW  = $clog2(HEADER_WORDS + 2);

   typedef enum logic [2:0] {
      ST_CAPTURE,
      ST_DECIDE,
      ST_MERGE,
      ST_DRAIN,
      ST_STREAM,
      ST_SECOND,
      ST_DISCARD
   } state_type;

   state_type    state_ff, state_in;
   logic [WSW-1:0] ws_ff, ws_in;
   logic [LW-1:0]  len_ff, len_in;
   logic         end_ff, end_in;
   verdict_type  verdict_ff, verdict_in;
   logic [16:0]  psum_ff [CSUM_LANES];
   logic [16:0]  psum_in [CSUM_LANES];
   logic [16:0]  psum_c  [CSUM_LANES];
   logic [63:0]  q_ff [HEADER_WORDS];
   logic [63:0]  q_in [HEADER_WORDS];
   logic [63:0]  q_load [HEADER_WORDS];
   logic [RW-1:0] left_ff, left_in;
   logic [3:0]   last_cnt_ff, last_cnt_in;
   logic         last_end_ff, last_end_in;
   logic [63:0]  carry_ff, carry_in;
   logic [2:0]   cc_ff, cc_in;
   logic [63:0]  sec_ff, sec_in;
   logic [3:0]   sec_cnt_ff, sec_cnt_in;
   logic [31:0]  target_ff;
   logic [63:0]  hdr_ff [HEADER_WORDS];

   logic [7:0]   hbyte [HB];
   logic [7:0]   ebyte [HB];

   logic [63:0]  in_word;
   logic [3:0]   in_cnt;
   logic [3:0]   c_eff;
   logic         acc;
   logic         push;
   rsp_item_type push_item;
   logic         space;
   rsp_item_type rsp_item;

   verdict_type  verdict_c;
   logic [LW-1:0] n_c;
   logic [2:0]   rem_c;
   logic         tail_c;
   logic [15:0]  cs_c;
   logic [19:0]  total_c;
   logic [16:0]  fold1_c;
   logic [16:0]  fold2_c;

   logic [63:0]  wm;
   logic [127:0] comb_s;
   logic [3:0]   n_s;

   logic         busy_st;
   logic         empty_rsp;

   assign in_word   = req_tdata[63:0];
   assign in_cnt    = req_tdata[67:64];
   assign c_eff     = !req_tlast ? 4'd8 : ((in_cnt > 4'd8) ? 4'd8 : in_cnt);
   assign req_tready = (state_ff == ST_CAPTURE) || (state_ff == ST_DISCARD) ||
                       ((state_ff == ST_STREAM) && space);
   assign acc       = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   // header bytes in frame order
   genvar g, j, b;
   for (g = 0; g < HB; g++) begin : g_hb
      assign hbyte[g] = hdr_ff[g / 8][63 - 8 * (g % 8) -: 8];
   end

   // verdict from the captured header
   always_comb begin
      priority if (len_ff < LW'(MIN_ETH_LEN)) begin
         verdict_c = V_ABORT;
      end else if ({hbyte[12], hbyte[13]} != ETHERTYPE_IPV4) begin
         verdict_c = V_PASS;
      end else if (len_ff < LW'(MIN_IP_LEN)) begin
         verdict_c = V_ABORT;
      end else if (hbyte[23] != PROTO_IPIP) begin
         verdict_c = V_PASS;
      end else if ({hbyte[30], hbyte[31], hbyte[32], hbyte[33]} != target_ff) begin
         verdict_c = V_DROP;
      end else if (len_ff < LW'(MIN_INNER_LEN)) begin
         verdict_c = V_DROP;
      end else if (hbyte[STRIP_BYTES + 23] == PROTO_TCP) begin
         verdict_c = V_REWRITTEN;
      end else if (len_ff < LW'(MIN_PORT_LEN)) begin
         verdict_c = V_DROP;
      end else begin
         verdict_c = V_TX;
      end
   end

   // checksum lanes; the check field itself counts as zero
   for (g = 0; g < CSUM_LANES; g++) begin : g_lane
      logic [15:0] lo_w;
      if (g == 2) begin : g_chk
         assign lo_w = 16'h0000;
      end else begin : g_data
         assign lo_w = {hbyte[CSUM_BASE + 4 * g + 2], hbyte[CSUM_BASE + 4 * g + 3]};
      end
      idr_csum_lane u_lane (
         .hi_word  ({hbyte[CSUM_BASE + 4 * g], hbyte[CSUM_BASE + 4 * g + 1]}),
         .lo_word  (lo_w),
         .part_sum (psum_c[g])
      );
   end

   // merge lanes and fold carries
   always_comb begin
      total_c = 20'd0;
      for (int i = 0; i < CSUM_LANES; i++) begin
         total_c = total_c + {3'b000, psum_ff[i]};
      end
      fold1_c = {1'b0, total_c[15:0]} + {13'd0, total_c[19:16]};
      fold2_c = {1'b0, fold1_c[15:0]} + {16'd0, fold1_c[16]};
      cs_c    = ~fold2_c[15:0];
   end

   // bytes to send from the header
   assign n_c    = (verdict_ff == V_PASS) ? len_ff : (len_ff - LW'(STRIP_BYTES));
   assign rem_c  = n_c[2:0];
   assign tail_c = end_ff && ((rem_c != 3'd0) || (n_c == '0));

   for (g = 0; g < HB; g++) begin : g_eb
      logic [7:0] rw_b;
      logic [7:0] tx_b;
      if (g < 6) begin : g_mac_a
         assign rw_b = hbyte[STRIP_BYTES + g + 6];
      end else if (g < 12) begin : g_mac_b
         assign rw_b = hbyte[STRIP_BYTES + g - 6];
      end else if (g >= 26 && g < 30) begin : g_ip_a
         assign rw_b = hbyte[STRIP_BYTES + g + 4];
      end else if (g >= 30 && g < 34) begin : g_ip_b
         assign rw_b = hbyte[STRIP_BYTES + g - 4];
      end else if (g + STRIP_BYTES < HB) begin : g_plain
         assign rw_b = hbyte[STRIP_BYTES + g];
      end else begin : g_none
         assign rw_b = 8'h00;
      end
      if (g == 24) begin : g_cs_hi
         assign tx_b = cs_c[15:8];
      end else if (g == 25) begin : g_cs_lo
         assign tx_b = cs_c[7:0];
      end else if (g == 34 || g == 35) begin : g_port_a
         assign tx_b = hbyte[STRIP_BYTES + g + 2];
      end else if (g == 36 || g == 37) begin : g_port_b
         assign tx_b = hbyte[STRIP_BYTES + g - 2];
      end else begin : g_keep
         assign tx_b = rw_b;
      end
      assign ebyte[g] = (LW'(g) < n_c) ?
                        ((verdict_ff == V_PASS) ? hbyte[g] :
                         ((verdict_ff == V_TX) ? tx_b : rw_b)) : 8'h00;
   end

   for (j = 0; j < HEADER_WORDS; j++) begin : g_q
      for (b = 0; b < 8; b++) begin : g_qb
         assign q_load[j][63 - 8 * b -: 8] = ebyte[8 * j + b];
      end
   end

   // body word joined behind the carried bytes
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         wm[63 - 8 * i -: 8] = (4'(i) < c_eff) ? in_word[63 - 8 * i -: 8] : 8'h00;
      end
      comb_s = {carry_ff, 64'h0} | ({wm, 64'h0} >> {cc_ff, 3'b000});
      n_s    = {1'b0, cc_ff} + c_eff;
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      ws_in       = ws_ff;
      len_in      = len_ff;
      end_in      = end_ff;
      verdict_in  = verdict_ff;
      left_in     = left_ff;
      last_cnt_in = last_cnt_ff;
      last_end_in = last_end_ff;
      carry_in    = carry_ff;
      cc_in       = cc_ff;
      sec_in      = sec_ff;
      sec_cnt_in  = sec_cnt_ff;
      psum_in     = psum_ff;
      q_in        = q_ff;
      push        = 1'b0;
      push_item   = '0;
      push_item.verdict = verdict_ff;
      unique case (state_ff)
         ST_CAPTURE: begin
            if (acc) begin
               len_in = LW'({ws_ff, 3'b000}) + LW'(c_eff);
               end_in = req_tlast;
               if (req_tlast || (ws_ff == WSW'(HEADER_WORDS - 1))) begin
                  ws_in    = '0;
                  state_in = ST_DECIDE;
               end else begin
                  ws_in = ws_ff + 1'b1;
               end
            end
         end
         ST_DECIDE: begin
            verdict_in = verdict_c;
            psum_in    = psum_c;
            state_in   = ST_MERGE;
         end
         ST_MERGE: begin
            q_in  = q_load;
            cc_in = rem_c;
            if ((verdict_ff == V_DROP) || (verdict_ff == V_ABORT)) begin
               q_in[0]     = '0;
               left_in     = RW'(1);
               last_cnt_in = 4'd0;
               last_end_in = 1'b1;
            end else begin
               left_in     = RW'(n_c >> 3) + RW'(tail_c);
               last_cnt_in = tail_c ? {1'b0, rem_c} : 4'd8;
               last_end_in = end_ff;
            end
            state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (space) begin
               push                = 1'b1;
               push_item.out_word  = q_ff[0];
               push_item.out_count = (left_ff == RW'(1)) ? last_cnt_ff : 4'd8;
               push_item.out_end   = (left_ff == RW'(1)) ? last_end_ff : 1'b0;
               for (int i = 0; i < HEADER_WORDS - 1; i++) begin
                  q_in[i] = q_ff[i + 1];
               end
               q_in[HEADER_WORDS - 1] = '0;
               left_in = left_ff - 1'b1;
               if (left_ff == RW'(1)) begin
                  carry_in = q_ff[1];
                  if (end_ff) begin
                     state_in = ST_CAPTURE;
                  end else if ((verdict_ff == V_DROP) || (verdict_ff == V_ABORT)) begin
                     state_in = ST_DISCARD;
                  end else begin
                     state_in = ST_STREAM;
                  end
               end
            end
         end
         ST_STREAM: begin
            if (acc) begin
               push                = 1'b1;
               push_item.out_word  = comb_s[127:64];
               push_item.out_count = (n_s >= 4'd8) ? 4'd8 : n_s;
               push_item.out_end   = req_tlast && (n_s <= 4'd8);
               if (!req_tlast) begin
                  carry_in = comb_s[63:0];
                  cc_in    = 3'(n_s - 4'd8);
               end else if (n_s > 4'd8) begin
                  sec_in     = comb_s[63:0];
                  sec_cnt_in = n_s - 4'd8;
                  state_in   = ST_SECOND;
               end else begin
                  state_in = ST_CAPTURE;
               end
            end
         end
         ST_SECOND: begin
            if (space) begin
               push                = 1'b1;
               push_item.out_word  = sec_ff;
               push_item.out_count = sec_cnt_ff;
               push_item.out_end   = 1'b1;
               state_in            = ST_CAPTURE;
            end
         end
         ST_DISCARD: begin
            if (acc && req_tlast) begin
               state_in = ST_CAPTURE;
            end
         end
         default: begin
            state_in = ST_CAPTURE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CAPTURE;
         ws_ff     <= '0;
         left_ff   <= '0;
         target_ff <= TARGET_RESET;
      end else begin
         state_ff <= state_in;
         ws_ff    <= ws_in;
         left_ff  <= left_in;
         if (csr_valid && csr_ready) begin
            target_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      end_ff      <= end_in;
      verdict_ff  <= verdict_in;
      psum_ff     <= psum_in;
      q_ff        <= q_in;
      last_cnt_ff <= last_cnt_in;
      last_end_ff <= last_end_in;
      carry_ff    <= carry_in;
      cc_ff       <= cc_in;
      sec_ff      <= sec_in;
      sec_cnt_ff  <= sec_cnt_in;
      if (acc && (state_ff == ST_CAPTURE)) begin
         hdr_ff[ws_ff] <= in_word;
      end
   end

   idr_out_fifo u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .space     (space),
      .pop_ready (rsp_tready),
      .pop_valid (rsp_tvalid),
      .pop_item  (rsp_item)
   );

   assign rsp_tdata = {4'h0, rsp_item.out_count, rsp_item.out_word};
   assign rsp_tlast = rsp_item.out_end;
   assign rsp_tuser = rsp_item.verdict;

   // terms for the checks below
   assign busy_st   = (state_ff == ST_DECIDE) || (state_ff == ST_MERGE) ||
                      (state_ff == ST_DRAIN) || (state_ff == ST_SECOND);
   assign empty_rsp = rsp_tvalid && (rsp_item.out_count == 4'd0);

   `IDR_ASSERT(a_push_space, clock, reset, push |-> space, "result pushed into full queue")
   `IDR_ASSERT(a_req_state, clock, reset, acc |-> !busy_st, "input transfer in busy state")
   `IDR_ASSERT(a_empty_last, clock, reset, empty_rsp |-> rsp_tlast, "empty result not last")
   `IDR_ASSERT_NR(a_reset_empty, clock, reset |=> !rsp_tvalid, "result valid after reset")

endmodule
